// File: rtl/core/teq_pkg.sv
// Shared types and constants for the timed event queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package teq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int TYPE_BITS   = 4;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TIME_BITS-1:0] FRAME_RESET = TIME_BITS'(69888);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_REBASE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                 command;
    logic [TIME_BITS-1:0] add_time;
    logic [TYPE_BITS-1:0] event_type;
    logic [TIME_BITS-1:0] now;
  } cmd_item_t;

  typedef struct packed {
    logic                 fired;
    logic [TYPE_BITS-1:0] fired_type;
    logic [TIME_BITS-1:0] fired_time;
    logic                 add_failed;
    logic [TIME_BITS-1:0] next_due;
    logic [CNT_BITS-1:0]  pending;
    logic                 last;
  } rsp_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] due_time;
    logic [TYPE_BITS-1:0] type_code;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    entry_t              data;
  } mem_wr_t;

endpackage

// File: rtl/core/teq_store.sv
// Event storage: one write port and one registered read port.
// Depends on teq_pkg for the entry type and depth.
`timescale 1ns / 1ps

module teq_store import teq_pkg::*; (
  input  logic                clk,
  input  mem_wr_t             wr,
  input  logic [IDX_BITS-1:0] rd_addr,
  output entry_t              rd_data
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/teq_alu.sv
// Shared subtractor: gives a - b and whether a >= b (unsigned).
// Depends on teq_pkg for the time width.
`timescale 1ns / 1ps

module teq_alu import teq_pkg::*; (
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  output logic [TIME_BITS-1:0] diff,
  output logic                 ge
);

  logic [TIME_BITS:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[TIME_BITS-1:0];
  assign ge   = ~wide[TIME_BITS];

endmodule

// File: rtl/core/teq_seq.sv
// Command sequencer: walks the event store one entry per cycle for add,
// run and rebase, and drives the shared subtractor. Depends on teq_pkg,
// teq_store and teq_alu.
`timescale 1ns / 1ps

module teq_seq import teq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_item_t            cmd,
  input  logic [TIME_BITS-1:0] frame_length,
  input  logic                 res_take,
  output logic                 res_load,
  output rsp_item_t            res
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_ADD_SCAN  = 7'b0000010,
    ST_ADD_SHIFT = 7'b0000100,
    ST_RUN_CHECK = 7'b0001000,
    ST_RUN_SHIFT = 7'b0010000,
    ST_REBASE    = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_t;

  state_t               state;
  cmd_item_t            cur;
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  ptr;
  logic [CNT_BITS-1:0]  pos;
  logic [IDX_BITS-1:0]  raddr;
  logic                 rvalid;
  entry_t               head;
  entry_t               popped;
  logic                 pop_held;
  logic                 res_fired;
  logic [TYPE_BITS-1:0] res_type;
  logic [TIME_BITS-1:0] res_time;
  logic                 res_failed;
  logic                 res_last;

  mem_wr_t              mem_wr;
  logic [IDX_BITS-1:0]  rd_addr;
  entry_t               rd_data;
  logic [TIME_BITS-1:0] alu_a;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS-1:0] alu_diff;
  logic                 alu_ge;
  logic                 more_due;
  logic                 add_done;

  teq_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  teq_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  assign cmd_ready = (state == ST_IDLE);
  assign res_load  = (state == ST_EMIT) && res_take;
  assign more_due  = (count != '0) && alu_ge;
  assign add_done  = (state == ST_ADD_SHIFT) && (ptr <= pos) && !rvalid;

  always_comb begin
    case (state)
      ST_RUN_CHECK: begin
        alu_a = cur.now;
        alu_b = head.due_time;
      end
      ST_ADD_SCAN: begin
        alu_a = rd_data.due_time;
        alu_b = cur.add_time;
      end
      default: begin
        alu_a = rd_data.due_time;
        alu_b = frame_length;
      end
    endcase
  end

  always_comb begin
    if (state == ST_ADD_SHIFT) begin
      rd_addr = IDX_BITS'(ptr - CNT_BITS'(1));
    end else begin
      rd_addr = ptr[IDX_BITS-1:0];
    end
  end

  always_comb begin
    mem_wr = '0;
    case (state)
      ST_ADD_SHIFT: begin
        if (rvalid) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = raddr + IDX_BITS'(1);
          mem_wr.data = rd_data;
        end else if (ptr <= pos) begin
          mem_wr.en             = 1'b1;
          mem_wr.addr           = pos[IDX_BITS-1:0];
          mem_wr.data.due_time  = cur.add_time;
          mem_wr.data.type_code = cur.event_type;
        end
      end
      ST_RUN_SHIFT: begin
        if (rvalid) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = raddr - IDX_BITS'(1);
          mem_wr.data = rd_data;
        end
      end
      ST_REBASE: begin
        if (rvalid) begin
          mem_wr.en             = 1'b1;
          mem_wr.addr           = raddr;
          mem_wr.data.due_time  = alu_diff;
          mem_wr.data.type_code = rd_data.type_code;
        end
      end
      default: begin
        mem_wr = '0;
      end
    endcase
  end

  always_comb begin
    res.fired      = res_fired;
    res.fired_type = res_type;
    res.fired_time = res_time;
    res.add_failed = res_failed;
    res.next_due   = (count == '0) ? '1 : head.due_time;
    res.pending    = count;
    res.last       = res_last;
  end

  // Mirror of slot 0 so the head is visible without a store read
  always_ff @(posedge clk) begin
    if (mem_wr.en && (mem_wr.addr == '0)) begin
      head <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rvalid     <= 1'b0;
      pop_held   <= 1'b0;
      res_fired  <= 1'b0;
      res_failed <= 1'b0;
      res_last   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur        <= cmd;
            ptr        <= '0;
            rvalid     <= 1'b0;
            pop_held   <= 1'b0;
            res_fired  <= 1'b0;
            res_type   <= '0;
            res_time   <= '0;
            res_failed <= (cmd.command == CMD_ADD) && (count == CNT_BITS'(QUEUE_DEPTH));
            res_last   <= 1'b1;
            case (cmd.command)
              CMD_ADD: begin
                if (count == CNT_BITS'(QUEUE_DEPTH)) begin
                  state <= ST_EMIT;
                end else begin
                  state <= ST_ADD_SCAN;
                end
              end
              CMD_RUN:    state <= ST_RUN_CHECK;
              CMD_REBASE: state <= ST_REBASE;
              default: begin
                count <= '0;
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_ADD_SCAN: begin
          // Find the first slot whose time is at or after the new one
          if (rvalid && alu_ge) begin
            pos    <= CNT_BITS'(raddr);
            ptr    <= count;
            rvalid <= 1'b0;
            state  <= ST_ADD_SHIFT;
          end else if (ptr == count) begin
            pos    <= count;
            ptr    <= count;
            rvalid <= 1'b0;
            state  <= ST_ADD_SHIFT;
          end else begin
            raddr  <= ptr[IDX_BITS-1:0];
            rvalid <= 1'b1;
            ptr    <= ptr + CNT_BITS'(1);
          end
        end
        ST_ADD_SHIFT: begin
          // Move the tail up one slot, last entry first
          if (ptr > pos) begin
            raddr  <= IDX_BITS'(ptr - CNT_BITS'(1));
            rvalid <= 1'b1;
            ptr    <= ptr - CNT_BITS'(1);
          end else begin
            rvalid <= 1'b0;
            if (!rvalid) begin
              count <= count + CNT_BITS'(1);
              state <= ST_EMIT;
            end
          end
        end
        ST_RUN_CHECK: begin
          if (pop_held) begin
            res_fired <= 1'b1;
            res_type  <= popped.type_code;
            res_time  <= popped.due_time;
            res_last  <= !more_due;
            state     <= ST_EMIT;
          end else if (more_due) begin
            popped <= head;
            ptr    <= CNT_BITS'(1);
            rvalid <= 1'b0;
            state  <= ST_RUN_SHIFT;
          end else begin
            res_fired <= 1'b0;
            res_type  <= '0;
            res_time  <= '0;
            res_last  <= 1'b1;
            state     <= ST_EMIT;
          end
        end
        ST_RUN_SHIFT: begin
          // Move every entry down one slot over the popped head
          if (ptr < count) begin
            raddr  <= ptr[IDX_BITS-1:0];
            rvalid <= 1'b1;
            ptr    <= ptr + CNT_BITS'(1);
          end else begin
            rvalid <= 1'b0;
            if (!rvalid) begin
              count    <= count - CNT_BITS'(1);
              pop_held <= 1'b1;
              state    <= ST_RUN_CHECK;
            end
          end
        end
        ST_REBASE: begin
          if (ptr < count) begin
            raddr  <= ptr[IDX_BITS-1:0];
            rvalid <= 1'b1;
            ptr    <= ptr + CNT_BITS'(1);
          end else begin
            rvalid <= 1'b0;
            if (!rvalid) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (res_take) begin
            if ((cur.command == CMD_RUN) && !res_last) begin
              pop_held <= 1'b0;
              state    <= ST_RUN_CHECK;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (cmd.command == CMD_CLEAR)) |=> (count == '0))
    else $error("clear left entries queued");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    add_done |=> (count == $past(count) + CNT_BITS'(1)))
    else $error("add did not grow the queue by one");

  a_fire_not_failed: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !(res.fired && res.add_failed))
    else $error("result both fired and failed");

  a_failed_is_full: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.add_failed) |-> (count == CNT_BITS'(QUEUE_DEPTH)))
    else $error("add failed with a free slot");

endmodule

// File: rtl/core/timed_event_queue.sv
// Top level of the timed event queue: frame length register, response
// register and the command sequencer. Depends on teq_pkg and teq_seq.
`timescale 1ns / 1ps

// The queue holds up to QUEUE_DEPTH events kept in due-time order, a new
// event going ahead of those with the same time. One command is taken at a
// time; cmd_ready stays low until its last response has been loaded into
// the response register. All store walks go through an event memory with one
// write port and one read port, at one entry per cycle. A held response
// register adds its wait to every response. Each response reports the head
// time (all ones when empty) and the number of queued events.

module timed_event_queue import teq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_item_t            cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_item_t            rsp,
  input  logic                 cfg_we,
  input  logic [TIME_BITS-1:0] cfg_wdata
);

  logic [TIME_BITS-1:0] frame_length;
  logic                 res_take;
  logic                 res_load;
  rsp_item_t            res;

  assign res_take = !rsp_valid || rsp_ready;

  teq_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .frame_length (frame_length),
    .res_take     (res_take),
    .res_load     (res_load),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_RESET;
    end else if (cfg_we) begin
      frame_length <= cfg_wdata;
    end
  end

  // Hold the response until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

// File: sim/testbench.sv
// Self-checking bench for timed_event_queue: a queued command driver with a shadow of
// the event queue, a response monitor, and frame length changes between phases.
// Depends on teq_pkg and the timed_event_queue RTL.
`timescale 1ns / 1ps

module testbench;
  import teq_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  cmd_item_t            cmd = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_item_t            rsp;
  logic                 cfg_we = 1'b0;
  logic [TIME_BITS-1:0] cfg_wdata = '0;

  // shadow copy of the event store and the frame register
  logic [TIME_BITS-1:0] shadow_time [QUEUE_DEPTH];
  logic [TYPE_BITS-1:0] shadow_type [QUEUE_DEPTH];
  int                   shadow_count = 0;
  logic [TIME_BITS-1:0] shadow_frame = FRAME_RESET;

  cmd_item_t            command_fifo [$];
  rsp_item_t            rsp_backlog [$];
  logic [TIME_BITS-1:0] tick = 32'd1000;
  int                   errors = 0;
  int                   cmds_taken = 0;
  int                   rsp_seen = 0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;

  timed_event_queue uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build one response from the shadow queue as it stands now.
  function automatic rsp_item_t queue_status(logic f, logic [TYPE_BITS-1:0] ty,
                                             logic [TIME_BITS-1:0] tm, logic failed,
                                             logic lst);
    rsp_item_t r;
    r.fired      = f;
    r.fired_type = ty;
    r.fired_time = tm;
    r.add_failed = failed;
    r.next_due   = (shadow_count != 0) ? shadow_time[0] : {TIME_BITS{1'b1}};
    r.pending    = CNT_BITS'(shadow_count);
    r.last       = lst;
    return r;
  endfunction

  function automatic void step_event_queue(cmd_item_t c);
    int                   pos;
    bit                   fired_any;
    logic [TIME_BITS-1:0] pop_time;
    logic [TYPE_BITS-1:0] pop_type;
    fired_any = 1'b0;
    case (c.command)
      CMD_ADD: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          rsp_backlog.push_back(queue_status(1'b0, '0, '0, 1'b1, 1'b1));
        end else begin
          // new event goes ahead of any entry with an equal or later time
          pos = 0;
          while (pos < shadow_count && shadow_time[pos] < c.add_time) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_time[i] = shadow_time[i-1];
            shadow_type[i] = shadow_type[i-1];
          end
          shadow_time[pos] = c.add_time;
          shadow_type[pos] = c.event_type;
          shadow_count++;
          rsp_backlog.push_back(queue_status(1'b0, '0, '0, 1'b0, 1'b1));
        end
      end
      CMD_RUN: begin
        while (shadow_count > 0 && shadow_time[0] <= c.now) begin
          pop_time = shadow_time[0];
          pop_type = shadow_type[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_time[i-1] = shadow_time[i];
            shadow_type[i-1] = shadow_type[i];
          end
          shadow_count--;
          fired_any = 1'b1;
          rsp_backlog.push_back(queue_status(1'b1, pop_type, pop_time, 1'b0,
                                !(shadow_count > 0 && shadow_time[0] <= c.now)));
        end
        if (!fired_any) rsp_backlog.push_back(queue_status(1'b0, '0, '0, 1'b0, 1'b1));
      end
      CMD_REBASE: begin
        // wrap in place; order of the slots is kept
        for (int i = 0; i < shadow_count; i++) shadow_time[i] = shadow_time[i] - shadow_frame;
        rsp_backlog.push_back(queue_status(1'b0, '0, '0, 1'b0, 1'b1));
      end
      default: begin
        shadow_count = 0;
        rsp_backlog.push_back(queue_status(1'b0, '0, '0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  task automatic post_command(cmd_t op, logic [TIME_BITS-1:0] t, logic [TYPE_BITS-1:0] ty,
                              logic [TIME_BITS-1:0] at);
    cmd_item_t c;
    c.command    = op;
    c.add_time   = t;
    c.event_type = ty;
    c.now        = at;
    command_fifo.push_back(c);
  endtask

  task automatic load_random(int n);
    int                   made;
    int                   pick;
    logic [TIME_BITS-1:0] t;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 4) begin
        // burst of adds that overflows the queue, then a wide run to drain it
        repeat (QUEUE_DEPTH + 1) begin
          post_command(CMD_ADD, tick + $urandom_range(0, 4095),
                       TYPE_BITS'($urandom_range(15)), $urandom);
          made++;
        end
        post_command(CMD_RUN, $urandom, TYPE_BITS'($urandom_range(15)),
                     tick + 32'h0010_0000);
        tick += 32'h0010_0000;
        made++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 8) t = $urandom;
        else if (pick < 11) t = '0;
        else if (pick < 14) t = '1;
        else if (pick < 40) t = tick + 16 * $urandom_range(0, 7);
        else t = tick + $urandom_range(0, 3000);
        pick = $urandom_range(99);
        if (pick < 50) begin
          post_command(CMD_ADD, t, TYPE_BITS'($urandom_range(15)), $urandom);
        end else if (pick < 85) begin
          post_command(CMD_RUN, $urandom, TYPE_BITS'($urandom_range(15)), t);
          tick += $urandom_range(0, 1500);
        end else if (pick < 96) begin
          post_command(CMD_REBASE, $urandom, TYPE_BITS'($urandom_range(15)), $urandom);
          tick -= shadow_frame;
        end else begin
          post_command(CMD_CLEAR, $urandom, TYPE_BITS'($urandom_range(15)), $urandom);
        end
        made++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (command_fifo.size() != 0 || cmd_valid || rsp_backlog.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame(logic [TIME_BITS-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    shadow_frame = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Command driver: predict on every accepted transaction, then offer the next item.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        step_event_queue(cmd);
        cmds_taken++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (command_fifo.size() != 0 &&
            ((cmds_taken >= 200 && cmds_taken < 280) || $urandom_range(99) >= 13)) begin
          cmd       <= command_fifo.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold so the block fills and stalls its command side.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && rsp_seen >= 80) begin
      hold_done <= 1'b1;
      hold_left <= 300;
    end
  end

  // Response monitor and receiver stalls.
  always @(posedge clk) begin : rsp_monitor
    rsp_item_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (rsp_backlog.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("response %0d with nothing outstanding: fired=%0b type=%0h time=%h",
                     rsp_seen, rsp.fired, rsp.fired_type, rsp.fired_time);
        end else begin
          want = rsp_backlog.pop_front();
          if (rsp.fired !== want.fired || rsp.fired_type !== want.fired_type ||
              rsp.fired_time !== want.fired_time || rsp.add_failed !== want.add_failed ||
              rsp.next_due !== want.next_due || rsp.pending !== want.pending ||
              rsp.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display({"response %0d expected: fired=%0b type=%0h time=%h",
                        " fail=%0b next=%h pend=%0d last=%0b"},
                       rsp_seen, want.fired, want.fired_type, want.fired_time,
                       want.add_failed, want.next_due, want.pending, want.last);
              $display({"response %0d actual:   fired=%0b type=%0h time=%h",
                        " fail=%0b next=%h pend=%0d last=%0b"},
                       rsp_seen, rsp.fired, rsp.fired_type, rsp.fired_time,
                       rsp.add_failed, rsp.next_due, rsp.pending, rsp.last);
            end
          end
        end
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= (rsp_seen >= 250 && rsp_seen < 350) || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, ties, extremes, overflow, wrap on rebase, clear
    post_command(CMD_RUN, '0, '0, '1);
    post_command(CMD_REBASE, '0, '0, '0);
    post_command(CMD_ADD, 32'd100, 4'd1, '0);
    post_command(CMD_ADD, 32'd100, 4'd2, '0);
    post_command(CMD_ADD, 32'd0, 4'd15, '0);
    post_command(CMD_ADD, '1, 4'd0, '0);
    post_command(CMD_ADD, 32'd50, 4'd7, '0);
    post_command(CMD_ADD, 32'd70000, 4'd3, '0);
    post_command(CMD_ADD, 32'd70000, 4'd4, '0);
    post_command(CMD_ADD, 32'd200000, 4'd5, '0);
    post_command(CMD_ADD, 32'd69000, 4'd6, '0);
    post_command(CMD_ADD, 32'd69887, 4'd8, '0);
    post_command(CMD_ADD, 32'd69888, 4'd9, '0);
    post_command(CMD_ADD, 32'd1, 4'd10, '0);
    post_command(CMD_ADD, 32'd300000, 4'd11, '0);
    post_command(CMD_ADD, 32'd150, 4'd12, '0);
    post_command(CMD_ADD, 32'd100, 4'd13, '0);
    post_command(CMD_ADD, 32'd65535, 4'd14, '0);
    post_command(CMD_ADD, 32'd42, 4'd5, '0);
    post_command(CMD_RUN, '0, '0, 32'd100);
    post_command(CMD_REBASE, '0, '0, '0);
    post_command(CMD_RUN, '0, '0, 32'h0001_0000);
    post_command(CMD_RUN, '0, '0, '1);
    post_command(CMD_ADD, 32'd5, 4'd3, '0);
    post_command(CMD_ADD, 32'd5, 4'd4, '0);
    post_command(CMD_CLEAR, '0, '0, '0);
    post_command(CMD_RUN, '0, '0, '1);
    drain();

    set_frame('0);
    load_random(88);
    drain();
    set_frame('1);
    load_random(88);
    drain();
    set_frame($urandom);
    load_random(88);
    drain();
    set_frame($urandom_range(1, 200000));
    load_random(88);
    drain();

    repeat (400) @(posedge clk);
    if (errors == 0 && rsp_backlog.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
